// ===== hdl/soim_pkg.sv =====
`default_nettype none

package soim_pkg;

	localparam int unsigned VAL_W = 31;

	// action codes
	localparam logic [2:0] ACT_BEGIN = 3'd0;
	localparam logic [2:0] ACT_APPEND = 3'd1;
	localparam logic [2:0] ACT_END = 3'd2;
	localparam logic [2:0] ACT_L2G = 3'd3;
	localparam logic [2:0] ACT_G2L = 3'd4;

	// status codes
	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_FULL = 4'd1;
	localparam logic [3:0] ST_NEG = 4'd2;
	localparam logic [3:0] ST_OVF = 4'd3;
	localparam logic [3:0] ST_MISMATCH = 4'd4;
	localparam logic [3:0] ST_NOT_BUILT = 4'd5;
	localparam logic [3:0] ST_ENTRY = 4'd6;
	localparam logic [3:0] ST_LOCAL = 4'd7;
	localparam logic [3:0] ST_GLOBAL = 4'd8;

	// sticky build error codes, equal to the low bits of the matching status
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_NEG = 2'd2;
	localparam logic [1:0] ERR_OVF = 2'd3;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	typedef logic [VAL_W-1:0] val_t;

	typedef struct packed {
		logic [2:0] action;
		logic signed [31:0] count;
		logic signed [31:0] entry_index;
		logic signed [31:0] local_index;
		logic signed [31:0] global_index;
	} in_item_t;

	typedef struct packed {
		logic [3:0] status;
		val_t found_global;
		val_t found_entry;
		val_t found_local;
	} out_item_t;

	typedef struct packed {
		logic valid;
		out_item_t item;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/soim_chan_if.sv =====
`default_nettype none

interface soim_chan_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/segment_offset_index_map.sv =====
// path from accept to response valid: begin, append, end, unused actions and failed checks
// pass decode and done; local to global adds a base read and a size read; global to local adds
// a search and a probe per step, at most ceil(log2(MAX_SEGMENTS+1)) steps, then a finish read
// throughput: one item in flight; each search step is one read of the offset table port
// reset clears the build state and the output valid; table contents stay undefined
`default_nettype none

module segment_offset_index_map #(
	parameter int unsigned MAX_SEGMENTS = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	soim_chan_if.sink request,
	soim_chan_if.source response,
	soim_chan_if.sink cfg
);

	localparam int unsigned DEPTH = MAX_SEGMENTS + 1;
	localparam int unsigned AW = $clog2(DEPTH);

	soim_pkg::val_t expected_total_q;
	soim_pkg::res_t res;
	logic res_ready;
	logic out_valid_q;
	soim_pkg::out_item_t out_item_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	soim_pkg::val_t mem_wdata, mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_total_q <= '0;
		end else if (cfg.valid) begin
			expected_total_q <= cfg.data;
		end
	end

	soim_ctrl #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(request.valid),
		.in_item(request.data),
		.in_ready(request.ready),
		.expected_total(expected_total_q),
		.res(res),
		.res_ready(res_ready),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	soim_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register is free when empty or being drained this cycle
	assign res_ready = !out_valid_q || response.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_item_q <= res.item;
		end
	end

	assign response.valid = out_valid_q;
	assign response.data = out_item_q;

endmodule

`default_nettype wire

// ===== hdl/soim_mem.sv =====
`default_nettype none

module soim_mem #(
	parameter int unsigned DEPTH = 257,
	parameter int unsigned AW = 9
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire soim_pkg::val_t wdata,
	input wire logic [AW-1:0] raddr,
	output soim_pkg::val_t rdata
);

	soim_pkg::val_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/soim_ctrl.sv =====
`default_nettype none

module soim_ctrl #(
	parameter int unsigned MAX_SEGMENTS = 256,
	parameter int unsigned AW = 9
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire soim_pkg::in_item_t in_item,
	output logic in_ready,
	input wire soim_pkg::val_t expected_total,
	output soim_pkg::res_t res,
	input wire logic res_ready,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output soim_pkg::val_t mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input wire soim_pkg::val_t mem_rdata
);

	localparam int unsigned PADW = soim_pkg::VAL_W - AW;
	localparam logic [AW-1:0] MAX_CNT = AW'(MAX_SEGMENTS);
	localparam logic [AW-1:0] ONE = AW'(1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_L2G_BASE = 8'b0000_0100,
		S_L2G_SIZE = 8'b0000_1000,
		S_SEARCH = 8'b0001_0000,
		S_PROBE = 8'b0010_0000,
		S_FINISH = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	soim_pkg::in_item_t item_q;
	logic [AW-1:0] seg_cnt_q, seg_cnt_d;
	soim_pkg::val_t total_q, total_d;
	logic [1:0] err_q, err_d;
	logic valid_q, valid_d;
	logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	soim_pkg::val_t base_q, base_d;
	soim_pkg::out_item_t res_q, res_d;

	soim_pkg::val_t seg_cnt_ext;
	soim_pkg::val_t seg_size;
	logic [AW-1:0] mid;

	assign seg_cnt_ext = {{PADW{1'b0}}, seg_cnt_q};
	assign seg_size = mem_rdata - base_q;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	assign in_ready = (state_q == S_IDLE);
	assign res.valid = (state_q == S_DONE);
	assign res.item = res_q;

	always_comb begin
		state_d = state_q;
		seg_cnt_d = seg_cnt_q;
		total_d = total_q;
		err_d = err_q;
		valid_d = valid_q;
		lo_d = lo_q;
		hi_d = hi_q;
		mid_d = mid_q;
		base_d = base_q;
		res_d = res_q;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_d = '0;
				state_d = S_DONE;
				case (item_q.action)
					soim_pkg::ACT_BEGIN: begin
						seg_cnt_d = '0;
						total_d = '0;
						err_d = soim_pkg::ERR_NONE;
						valid_d = 1'b0;
						mem_we = 1'b1;
					end
					soim_pkg::ACT_APPEND: begin
						valid_d = 1'b0;
						if (err_q == soim_pkg::ERR_NONE) begin
							if (seg_cnt_q == MAX_CNT) begin
								err_d = soim_pkg::ERR_FULL;
							end else if (item_q.count[31]) begin
								err_d = soim_pkg::ERR_NEG;
							end else if (item_q.count[30:0] > (soim_pkg::VAL_MAX - total_q)) begin
								err_d = soim_pkg::ERR_OVF;
							end else begin
								total_d = total_q + item_q.count[30:0];
								seg_cnt_d = seg_cnt_q + ONE;
								mem_we = 1'b1;
								mem_waddr = seg_cnt_q + ONE;
								mem_wdata = total_q + item_q.count[30:0];
							end
						end
						res_d.status = {2'b00, err_d};
					end
					soim_pkg::ACT_END: begin
						if (err_q != soim_pkg::ERR_NONE) begin
							valid_d = 1'b0;
							res_d.status = {2'b00, err_q};
						end else if (total_q != expected_total) begin
							valid_d = 1'b0;
							res_d.status = soim_pkg::ST_MISMATCH;
						end else begin
							valid_d = 1'b1;
						end
					end
					soim_pkg::ACT_L2G: begin
						if (!valid_q) begin
							res_d.status = soim_pkg::ST_NOT_BUILT;
						end else if (item_q.entry_index[31]
								|| item_q.entry_index[30:0] >= seg_cnt_ext) begin
							res_d.status = soim_pkg::ST_ENTRY;
						end else begin
							mem_raddr = item_q.entry_index[AW-1:0];
							state_d = S_L2G_BASE;
						end
					end
					soim_pkg::ACT_G2L: begin
						if (!valid_q) begin
							res_d.status = soim_pkg::ST_NOT_BUILT;
						end else if (item_q.global_index[31]
								|| item_q.global_index[30:0] >= total_q) begin
							res_d.status = soim_pkg::ST_GLOBAL;
						end else begin
							lo_d = '0;
							hi_d = seg_cnt_q;
							state_d = S_SEARCH;
						end
					end
					default: begin
						res_d.status = soim_pkg::ST_OK;
					end
				endcase
			end
			S_L2G_BASE: begin
				base_d = mem_rdata;
				mem_raddr = item_q.entry_index[AW-1:0] + ONE;
				state_d = S_L2G_SIZE;
			end
			S_L2G_SIZE: begin
				if (item_q.local_index[31] || item_q.local_index[30:0] >= seg_size) begin
					res_d.status = soim_pkg::ST_LOCAL;
				end else begin
					res_d.found_global = base_q + item_q.local_index[30:0];
				end
				state_d = S_DONE;
			end
			S_SEARCH: begin
				if (lo_q < hi_q) begin
					mid_d = mid;
					mem_raddr = mid + ONE;
					state_d = S_PROBE;
				end else begin
					mem_raddr = lo_q;
					state_d = S_FINISH;
				end
			end
			S_PROBE: begin
				// upper bound of segment mid against the flat index
				if (mem_rdata <= item_q.global_index[30:0]) begin
					lo_d = mid_q + ONE;
				end else begin
					hi_d = mid_q;
				end
				state_d = S_SEARCH;
			end
			S_FINISH: begin
				res_d.found_entry = {{PADW{1'b0}}, lo_q};
				res_d.found_local = item_q.global_index[30:0] - mem_rdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seg_cnt_q <= '0;
			total_q <= '0;
			err_q <= soim_pkg::ERR_NONE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seg_cnt_q <= seg_cnt_d;
			total_q <= total_d;
			err_q <= err_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
		lo_q <= lo_d;
		hi_q <= hi_d;
		mid_q <= mid_d;
		base_q <= base_d;
		res_q <= res_d;
	end

endmodule

`default_nettype wire

// ===== tb/segment_offset_index_map_test.sv =====
`timescale 1ns / 100ps

module segment_offset_index_map_test;

	localparam int MAX_SEG = 256;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS = 300;
	localparam int TIMEOUT_NS = 5_000_000;

	logic clk = 1'b0;
	logic arst_n;

	soim_chan_if #(.payload_t(soim_pkg::in_item_t)) req_ch ();
	soim_chan_if #(.payload_t(soim_pkg::out_item_t)) rsp_ch ();
	soim_chan_if #(.payload_t(soim_pkg::val_t)) cfg_ch ();

	segment_offset_index_map #(.MAX_SEGMENTS(MAX_SEG)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.response(rsp_ch),
		.cfg(cfg_ch)
	);

	// predicted copy of the map state
	soim_pkg::val_t seg_offsets [0:MAX_SEG];
	int seg_num = 0;
	soim_pkg::val_t seg_total = '0;
	logic [1:0] sticky_err = soim_pkg::ERR_NONE;
	bit map_valid = 1'b0;
	soim_pkg::val_t want_total = '0;

	soim_pkg::out_item_t pending_results[$];
	int fail_count = 0;
	int items_sent = 0;
	int send_burst_left = 0;
	bit hold_rsp = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic soim_pkg::out_item_t index_map_result(input soim_pkg::in_item_t it);
		soim_pkg::out_item_t r;
		logic [31:0] cnt, ent, loc, glb;
		soim_pkg::val_t base, size;
		int lo, hi, mid;
		r = '0;
		r.status = soim_pkg::ST_OK;
		cnt = it.count;
		ent = it.entry_index;
		loc = it.local_index;
		glb = it.global_index;
		case (it.action)
		soim_pkg::ACT_BEGIN: begin
			seg_num = 0;
			seg_total = '0;
			sticky_err = soim_pkg::ERR_NONE;
			map_valid = 1'b0;
			seg_offsets[0] = '0;
		end
		soim_pkg::ACT_APPEND: begin
			map_valid = 1'b0;
			if (sticky_err == soim_pkg::ERR_NONE) begin
				if (seg_num >= MAX_SEG)
					sticky_err = soim_pkg::ERR_FULL;
				else if (cnt[31])
					sticky_err = soim_pkg::ERR_NEG;
				else if (cnt > {1'b0, soim_pkg::VAL_MAX - seg_total})
					sticky_err = soim_pkg::ERR_OVF;
				else begin
					seg_total = seg_total + cnt[30:0];
					seg_num++;
					seg_offsets[seg_num] = seg_total;
				end
			end
			r.status = {2'b00, sticky_err};
		end
		soim_pkg::ACT_END: begin
			if (sticky_err != soim_pkg::ERR_NONE) begin
				map_valid = 1'b0;
				r.status = {2'b00, sticky_err};
			end else if (seg_total != want_total) begin
				map_valid = 1'b0;
				r.status = soim_pkg::ST_MISMATCH;
			end else begin
				map_valid = 1'b1;
			end
		end
		soim_pkg::ACT_L2G: begin
			if (!map_valid)
				r.status = soim_pkg::ST_NOT_BUILT;
			else if (ent[31] || ent >= 32'(seg_num))
				r.status = soim_pkg::ST_ENTRY;
			else begin
				base = seg_offsets[ent];
				size = seg_offsets[ent + 1] - base;
				if (loc[31] || loc >= {1'b0, size})
					r.status = soim_pkg::ST_LOCAL;
				else
					r.found_global = base + loc[30:0];
			end
		end
		soim_pkg::ACT_G2L: begin
			if (!map_valid)
				r.status = soim_pkg::ST_NOT_BUILT;
			else if (glb[31] || glb >= {1'b0, seg_offsets[seg_num]})
				r.status = soim_pkg::ST_GLOBAL;
			else begin
				// last segment whose start is not above the flat index
				lo = 0;
				hi = seg_num;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (seg_offsets[mid + 1] <= glb[30:0])
						lo = mid + 1;
					else
						hi = mid;
				end
				r.found_entry = soim_pkg::val_t'(lo);
				r.found_local = glb[30:0] - seg_offsets[lo];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(input soim_pkg::in_item_t it);
		int gap;
		if (send_burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			send_burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		send_burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_results.push_back(index_map_result(it));
		items_sent++;
	endtask

	// drop valid and let the block finish whatever it still holds
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		send_burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_expected_total(input soim_pkg::val_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		want_total = v;
	endtask

	function automatic soim_pkg::in_item_t random_fields(input logic [2:0] act);
		soim_pkg::in_item_t it;
		it.action = act;
		it.count = $urandom;
		it.entry_index = $urandom;
		it.local_index = $urandom;
		it.global_index = $urandom;
		return it;
	endfunction

	task automatic send_op(input logic [2:0] act);
		send_item(random_fields(act));
	endtask

	task automatic send_append(input logic [31:0] c);
		soim_pkg::in_item_t it;
		it = random_fields(soim_pkg::ACT_APPEND);
		it.count = c;
		send_item(it);
	endtask

	task automatic send_l2g(input logic [31:0] e, input logic [31:0] l);
		soim_pkg::in_item_t it;
		it = random_fields(soim_pkg::ACT_L2G);
		it.entry_index = e;
		it.local_index = l;
		send_item(it);
	endtask

	task automatic send_g2l(input logic [31:0] g);
		soim_pkg::in_item_t it;
		it = random_fields(soim_pkg::ACT_G2L);
		it.global_index = g;
		send_item(it);
	endtask

	// lookups aimed mostly at the current table, edges included
	task automatic send_random_lookup();
		soim_pkg::in_item_t it;
		int unsigned e, sz, pick;
		it = random_fields(soim_pkg::ACT_L2G);
		pick = $urandom_range(0, 9);
		if ($urandom_range(0, 1) == 0) begin
			if (seg_num > 0 && pick < 8) begin
				e = $urandom_range(0, seg_num - 1);
				sz = seg_offsets[e + 1] - seg_offsets[e];
				it.entry_index = e;
				if (sz > 0 && pick < 6)
					it.local_index = (pick == 0) ? sz - 1 : $urandom_range(0, sz - 1);
				else if (pick < 7)
					it.local_index = sz;
			end else if (pick == 8) begin
				it.entry_index = seg_num;
			end
		end else begin
			it.action = soim_pkg::ACT_G2L;
			if (seg_num > 0 && pick == 1)
				it.global_index = seg_offsets[$urandom_range(0, seg_num - 1)];
			else if (seg_total > 0 && pick < 7)
				it.global_index = (pick == 0) ? seg_total - 1
					: $urandom_range(0, seg_total - 1);
			else if (pick < 8)
				it.global_index = seg_total;
		end
		send_item(it);
	endtask

	task automatic test_before_build();
		send_op(soim_pkg::ACT_L2G);
		send_op(soim_pkg::ACT_G2L);
		send_op(3'd7);
	endtask

	task automatic test_basic_map();
		wait_idle();
		write_expected_total(soim_pkg::val_t'(15));
		send_op(soim_pkg::ACT_BEGIN);
		send_append(10);
		send_append(0);
		send_append(5);
		send_op(soim_pkg::ACT_END);
		send_l2g(2, 4);
		send_l2g(1, 0);
		send_l2g(3, 0);
		send_g2l(9);
		send_g2l(10);
		send_g2l(15);
	endtask

	task automatic test_build_errors();
		wait_idle();
		write_expected_total(soim_pkg::val_t'(7));
		send_op(soim_pkg::ACT_BEGIN);
		send_append(-1);
		send_append(3);
		send_op(soim_pkg::ACT_END);
		send_op(soim_pkg::ACT_BEGIN);
		send_append({1'b0, soim_pkg::VAL_MAX});
		send_append(1);
		send_op(soim_pkg::ACT_BEGIN);
		send_append(32'h8000_0000);
		send_op(soim_pkg::ACT_BEGIN);
		send_append(3);
		send_op(soim_pkg::ACT_END);
	endtask

	task automatic test_empty_map();
		wait_idle();
		write_expected_total('0);
		send_op(soim_pkg::ACT_BEGIN);
		send_op(soim_pkg::ACT_END);
		send_g2l(0);
	endtask

	task automatic test_max_total();
		wait_idle();
		write_expected_total(soim_pkg::VAL_MAX);
		send_op(soim_pkg::ACT_BEGIN);
		send_append({1'b0, soim_pkg::VAL_MAX});
		send_op(soim_pkg::ACT_END);
		send_l2g(0, {1'b0, soim_pkg::VAL_MAX} - 1);
		send_g2l({1'b0, soim_pkg::VAL_MAX} - 1);
	endtask

	// response side held off while requests keep coming
	task automatic test_backpressure();
		hold_rsp = 1'b1;
		repeat (12) send_random_lookup();
		wait_idle();
	endtask

	task automatic test_full_table();
		int unsigned sizes[MAX_SEG];
		longint unsigned sum;
		sum = 0;
		foreach (sizes[i]) begin
			sizes[i] = $urandom_range(0, 5000);
			sum += sizes[i];
		end
		wait_idle();
		write_expected_total(soim_pkg::val_t'(sum));
		send_op(soim_pkg::ACT_BEGIN);
		foreach (sizes[i]) send_append(sizes[i]);
		send_op(soim_pkg::ACT_END);
		repeat (24) send_random_lookup();
		send_append($urandom_range(0, 100));
		send_op(soim_pkg::ACT_END);
		send_random_lookup();
	endtask

	task automatic run_build_session();
		int unsigned nseg, c, cap;
		int unsigned seg_sizes[$];
		longint unsigned sum;
		int r;
		soim_pkg::val_t target;
		nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
		cap = (nseg == 0) ? 1 : soim_pkg::VAL_MAX / nseg;
		sum = 0;
		repeat (nseg) begin
			case ($urandom_range(0, 3))
			0: c = $urandom_range(0, 3);
			1: c = $urandom_range(0, 200);
			2: c = $urandom_range(0, 1 << 20);
			default: c = $urandom_range(0, cap);
			endcase
			seg_sizes.push_back(c);
			sum += c;
		end
		r = $urandom_range(0, 9);
		if (r == 0)
			target = soim_pkg::val_t'(sum + 1);
		else if (r == 1)
			target = soim_pkg::val_t'($urandom);
		else
			target = soim_pkg::val_t'(sum);
		wait_idle();
		write_expected_total(target);
		send_op(soim_pkg::ACT_BEGIN);
		foreach (seg_sizes[i]) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				send_item(random_fields(3'($urandom_range(0, 7))));
			else if (r < 6)
				send_append(32'h8000_0000 | $urandom);
			else if (r < 8 && seg_total > 0)
				send_append((soim_pkg::VAL_MAX - seg_total) + 1
					+ $urandom_range(0, seg_total - 1));
			else
				send_append(seg_sizes[i]);
		end
		if ($urandom_range(0, 19) != 0)
			send_op(soim_pkg::ACT_END);
		repeat ($urandom_range(6, 20)) begin
			if ($urandom_range(0, 9) == 0)
				send_item(random_fields(3'($urandom_range(5, 7))));
			else
				send_random_lookup();
		end
	endtask

	task automatic test_random_sessions();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) run_build_session();
	endtask

	// receiver: changing ready rhythm, plus one long hold-off on request
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(8, 80);
			end
			left--;
			case (mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			2: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= (left % 5 < 2);
			endcase
		end
	end

	always @(posedge clk) begin
		soim_pkg::out_item_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: transfer with nothing pending, status %0d", $time,
						rsp_ch.data.status);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.data.status !== want.status
						|| rsp_ch.data.found_global !== want.found_global
						|| rsp_ch.data.found_entry !== want.found_entry
						|| rsp_ch.data.found_local !== want.found_local) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"%0t: expected st %0d g %0d e %0d l %0d,",
							" got st %0d g %0d e %0d l %0d"},
							$time, want.status, want.found_global, want.found_entry,
							want.found_local, rsp_ch.data.status, rsp_ch.data.found_global,
							rsp_ch.data.found_entry, rsp_ch.data.found_local);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("segment_offset_index_map_test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		foreach (seg_offsets[i]) seg_offsets[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_build();
		test_basic_map();
		test_build_errors();
		test_empty_map();
		test_max_total();
		test_backpressure();
		test_full_table();
		test_random_sessions();
		wait_idle();
		if (fail_count == 0)
			$display("segment_offset_index_map_test passed");
		else
			$display("segment_offset_index_map_test failed");
		$finish;
	end

endmodule

// ===== segment_offset_index_map.f =====
hdl/soim_pkg.sv
hdl/soim_chan_if.sv
hdl/soim_mem.sv
hdl/soim_ctrl.sv
hdl/segment_offset_index_map.sv
tb/segment_offset_index_map_test.sv
